[rtl/lcdt_pkg.sv]
// Package: shared constants, codes and structure types of the LCD line and mode timer.
`default_nettype none

package lcdt_pkg;

    localparam int CYCLES_W    = 7;
    localparam int LINE_W      = 8;
    localparam int DOT_W       = 10;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;

    localparam logic [DOT_W-1:0] OAM_DOTS    = 10'd80;
    localparam logic [DOT_W-1:0] DRAW_DOTS   = 10'd172;
    localparam logic [DOT_W-1:0] HBLANK_DOTS = 10'd204;
    localparam logic [DOT_W-1:0] LINE_DOTS   = 10'd456;
    localparam logic [DOT_W-1:0] DOT_MAX     = 10'd1023;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_DMA  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_LCD_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_LINE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COINC_IRQ_SEL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_IRQ_SEL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VBLANK_IRQ_SEL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OAM_IRQ_SEL   = 3'd5;

    typedef enum logic [3:0] {
        PH_HBLANK = 4'b0001,
        PH_VBLANK = 4'b0010,
        PH_OAM    = 4'b0100,
        PH_DRAW   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              lcd_enable;
        logic [LINE_W-1:0] compare_line;
        logic              coinc_irq_sel;
        logic              hblank_irq_sel;
        logic              vblank_irq_sel;
        logic              oam_irq_sel;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [LINE_W-1:0] line;
        logic [DOT_W-1:0]  dots;
        logic [DOT_W-1:0]  dma_left;
        logic              match;
    } timing_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LINE_W-1:0] line;
        logic              line_match;
        logic              vblank_irq;
        logic              stat_irq;
        logic              sprite_search;
        logic              render_line;
        logic              vram_open;
        logic              oam_open;
        logic              dma_busy;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(phase_t ph);
        logic [MODE_W-1:0] code;
        case (ph)
            PH_HBLANK: code = MODE_HBLANK;
            PH_VBLANK: code = MODE_VBLANK;
            PH_OAM:    code = MODE_OAM;
            PH_DRAW:   code = MODE_DRAW;
            default:   code = MODE_VBLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/lcdt_ifs.sv]
// Interfaces: tick input channel, result output channel and configuration write channel.
`default_nettype none

interface lcdt_tick_if
    import lcdt_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic                op;
    logic [CYCLES_W-1:0] cycles;

    modport source (output valid, output op, output cycles, input ready);
    modport sink (input valid, input op, input cycles, output ready);
endinterface

interface lcdt_result_if
    import lcdt_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic              line_match;
    logic              vblank_irq;
    logic              stat_irq;
    logic              sprite_search;
    logic              render_line;
    logic              vram_open;
    logic              oam_open;
    logic              dma_busy;

    modport source (
        output valid, output mode, output line, output line_match, output vblank_irq,
        output stat_irq, output sprite_search, output render_line, output vram_open,
        output oam_open, output dma_busy, input ready
    );
    modport sink (
        input valid, input mode, input line, input line_match, input vblank_irq,
        input stat_irq, input sprite_search, input render_line, input vram_open,
        input oam_open, input dma_busy, output ready
    );
endinterface

interface lcdt_cfg_if
    import lcdt_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/lcdt_step.sv]
// Next-state and result logic of the timer for one tick or DMA start.
`default_nettype none

module lcdt_step
    import lcdt_pkg::*;
#(
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154,
    parameter int DMA_LENGTH    = 640
) (
    input  wire logic                op,
    input  wire logic [CYCLES_W-1:0] cycles,
    input  wire cfg_t                cfg,
    input  wire timing_t             cur,
    output timing_t                  nxt,
    output result_t                  res
);

    localparam logic [LINE_W-1:0] VIS_LINE   = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] TOTAL_LINE = LINE_W'(TOTAL_LINES);
    localparam logic [DOT_W-1:0]  DMA_LOAD   = DOT_W'(DMA_LENGTH);

    logic [DOT_W:0]      dot_sum;
    logic [DOT_W-1:0]    dot_sat;
    logic [DOT_W-1:0]    cyc_ext;
    logic [DOT_W-1:0]    dma_sub;
    logic [LINE_W-1:0]   line_inc;
    logic                inc_match;
    logic                entered;
    logic                coinc;
    logic                vb_pulse;
    logic                search;
    logic                render;
    logic                mode_irq;

    assign cyc_ext   = DOT_W'(cycles);
    assign dot_sum   = {1'b0, cur.dots} + {1'b0, cyc_ext};
    assign dot_sat   = dot_sum[DOT_W] ? DOT_MAX : dot_sum[DOT_W-1:0];
    assign dma_sub   = (cur.dma_left > cyc_ext) ? (cur.dma_left - cyc_ext) : '0;
    assign line_inc  = cur.line + 8'd1;
    assign inc_match = (line_inc == cfg.compare_line);

    always_comb
    begin
        nxt      = cur;
        entered  = 1'b0;
        coinc    = 1'b0;
        vb_pulse = 1'b0;
        search   = 1'b0;
        render   = 1'b0;
        if (op == OP_DMA)
        begin
            nxt.dma_left = DMA_LOAD;
        end
        else if (!cfg.lcd_enable)
        begin
            nxt.dots  = '0;
            nxt.line  = '0;
            nxt.phase = PH_HBLANK;
            entered   = 1'b1;
        end
        else
        begin
            nxt.dma_left = dma_sub;
            nxt.dots     = dot_sat;
            case (cur.phase)
                PH_OAM:
                begin
                    if (dot_sat >= OAM_DOTS)
                    begin
                        nxt.dots  = dot_sat - OAM_DOTS;
                        search    = 1'b1;
                        nxt.phase = PH_DRAW;
                        entered   = 1'b1;
                    end
                end
                PH_DRAW:
                begin
                    if (dot_sat >= DRAW_DOTS)
                    begin
                        nxt.dots  = dot_sat - DRAW_DOTS;
                        render    = 1'b1;
                        nxt.phase = PH_HBLANK;
                        entered   = 1'b1;
                    end
                end
                PH_HBLANK:
                begin
                    if (dot_sat >= HBLANK_DOTS)
                    begin
                        nxt.dots  = dot_sat - HBLANK_DOTS;
                        nxt.line  = line_inc;
                        nxt.match = inc_match;
                        coinc     = inc_match;
                        entered   = 1'b1;
                        if (line_inc == VIS_LINE)
                        begin
                            vb_pulse  = 1'b1;
                            nxt.phase = PH_VBLANK;
                        end
                        else
                        begin
                            nxt.phase = PH_OAM;
                        end
                    end
                end
                default:
                begin
                    if (dot_sat >= LINE_DOTS)
                    begin
                        nxt.dots  = dot_sat - LINE_DOTS;
                        nxt.line  = line_inc;
                        nxt.match = inc_match;
                        coinc     = inc_match;
                        if (line_inc >= TOTAL_LINE)
                        begin
                            nxt.line  = '0;
                            nxt.phase = PH_OAM;
                            entered   = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign mode_irq = entered &&
                      (((nxt.phase == PH_HBLANK) && cfg.hblank_irq_sel) ||
                       ((nxt.phase == PH_VBLANK) && cfg.vblank_irq_sel) ||
                       ((nxt.phase == PH_OAM) && cfg.oam_irq_sel));

    always_comb
    begin
        res.mode          = mode_code(nxt.phase);
        res.line          = nxt.line;
        res.line_match    = nxt.match;
        res.vblank_irq    = vb_pulse;
        res.stat_irq      = mode_irq || (coinc && cfg.coinc_irq_sel);
        res.sprite_search = search;
        res.render_line   = render;
        res.vram_open     = (nxt.phase != PH_DRAW) && (nxt.dma_left == '0);
        res.oam_open      = (nxt.phase != PH_OAM) && (nxt.phase != PH_DRAW);
        res.dma_busy      = (nxt.dma_left != '0);
    end

endmodule

`default_nettype wire

[rtl/lcdt_out_stage.sv]
// Result register that holds one finished result until the sink takes it.
`default_nettype none

module lcdt_out_stage
    import lcdt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    out_ready,
    output logic         free,
    output logic         out_valid,
    output result_t      out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/lcd_line_mode_timer.sv]
// Top level of the LCD line and mode timer: registers, configuration and channel glue.
// Latency: a result appears in the cycle after its tick transfer, from the result register.
// Throughput: one tick per cycle unless results stall; timing state loads at transfer.
// A tick is taken whenever the result register is empty or is being read out.
// Reset clears the timing state to OAM scan at line 0, all configuration registers to 0,
// and empties the result register.
`default_nettype none

module lcd_line_mode_timer
    import lcdt_pkg::*;
#(
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154,
    parameter int DMA_LENGTH    = 640
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lcdt_cfg_if.sink      cfg,
    lcdt_tick_if.sink     tick,
    lcdt_result_if.source result
);

    timing_t timing_reg;
    timing_t timing_next;
    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    result_t step_res;
    result_t out_data;
    logic    out_free;
    logic    tick_xfer;

    assign tick.ready = out_free;
    assign tick_xfer  = tick.valid && out_free;
    assign cfg.ready  = 1'b1;

    lcdt_step #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES),
        .DMA_LENGTH    (DMA_LENGTH)
    ) u_step (
        .op     (tick.op),
        .cycles (tick.cycles),
        .cfg    (cfg_reg),
        .cur    (timing_reg),
        .nxt    (timing_next),
        .res    (step_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LCD_ENABLE:     cfg_next.lcd_enable     = cfg.data[0];
                REG_COMPARE_LINE:   cfg_next.compare_line   = cfg.data[LINE_W-1:0];
                REG_COINC_IRQ_SEL:  cfg_next.coinc_irq_sel  = cfg.data[0];
                REG_HBLANK_IRQ_SEL: cfg_next.hblank_irq_sel = cfg.data[0];
                REG_VBLANK_IRQ_SEL: cfg_next.vblank_irq_sel = cfg.data[0];
                REG_OAM_IRQ_SEL:    cfg_next.oam_irq_sel    = cfg.data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= '0;
            timing_reg.phase  <= PH_OAM;
            timing_reg.line   <= '0;
            timing_reg.dots   <= '0;
            timing_reg.dma_left <= '0;
            timing_reg.match  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (tick_xfer)
            begin
                timing_reg <= timing_next;
            end
        end
    end

    lcdt_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (tick_xfer),
        .load_data (step_res),
        .out_ready (result.ready),
        .free      (out_free),
        .out_valid (result.valid),
        .out_data  (out_data)
    );

    assign result.mode          = out_data.mode;
    assign result.line          = out_data.line;
    assign result.line_match    = out_data.line_match;
    assign result.vblank_irq    = out_data.vblank_irq;
    assign result.stat_irq      = out_data.stat_irq;
    assign result.sprite_search = out_data.sprite_search;
    assign result.render_line   = out_data.render_line;
    assign result.vram_open     = out_data.vram_open;
    assign result.oam_open      = out_data.oam_open;
    assign result.dma_busy      = out_data.dma_busy;

endmodule

`default_nettype wire

[rtl/lcdt_checker.sv]
// Port checker for the LCD line and mode timer, bound to the top level.
`default_nettype none

module lcdt_checker
    import lcdt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              tick_valid,
    input wire logic              tick_ready,
    input wire logic              tick_op,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [MODE_W-1:0] res_mode,
    input wire logic [LINE_W-1:0] res_line,
    input wire logic              res_vblank_irq,
    input wire logic              res_sprite_search,
    input wire logic              res_render_line,
    input wire logic              res_vram_open,
    input wire logic              res_oam_open,
    input wire logic              res_dma_busy
);

    // A stalled result keeps its place, its mode and its line.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_mode) && $stable(res_line))
        else $error("result changed while stalled");

    // Every tick transfer produces a result in the next cycle.
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> res_valid)
        else $error("tick transfer without a following result");

    // A DMA start marks DMA busy, closes VRAM access and raises no timing pulses.
    a_dma_start: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready && (tick_op == OP_DMA) |=>
            res_dma_busy && !res_vram_open && !res_vblank_irq &&
            !res_sprite_search && !res_render_line)
        else $error("DMA start result is wrong");

    // The access flags agree with the reported mode and DMA state.
    a_access_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            (res_oam_open == ((res_mode != MODE_OAM) && (res_mode != MODE_DRAW))) &&
            (res_vram_open == ((res_mode != MODE_DRAW) && !res_dma_busy)))
        else $error("access flags disagree with mode");

    // Mode pulses come with the mode that the transition enters.
    a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            (!res_sprite_search || (res_mode == MODE_DRAW)) &&
            (!res_render_line || (res_mode == MODE_HBLANK)) &&
            (!res_vblank_irq || (res_mode == MODE_VBLANK)))
        else $error("pulse does not match mode");

endmodule

bind lcd_line_mode_timer lcdt_checker u_lcdt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .tick_valid        (tick.valid),
    .tick_ready        (tick.ready),
    .tick_op           (tick.op),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_mode          (result.mode),
    .res_line          (result.line),
    .res_vblank_irq    (result.vblank_irq),
    .res_sprite_search (result.sprite_search),
    .res_render_line   (result.render_line),
    .res_vram_open     (result.vram_open),
    .res_oam_open      (result.oam_open),
    .res_dma_busy      (result.dma_busy)
);

`default_nettype wire
